// File: design/assert_macros.svh
// Assertion helpers used by huffman_code_bit_packer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication or plain property checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// File: design/hcbp_pkg.sv
package hcbp_pkg;

   // Request codes
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_ENCODE = 2'd1;
   localparam logic [1:0] REQ_FLUSH  = 2'd2;

   // Code word field width and width of the code length field
   localparam int CODE_W     = 32;
   localparam int LEN_FIELD_W = 6;

   // Position of the first bit filled in an output byte
   localparam logic [2:0] TOP_BIT = 3'd7;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [7:0]             symbol;
      logic [CODE_W-1:0]      code_bits;
      logic [LEN_FIELD_W-1:0] code_length;
   } hcbp_req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       padded;
   } hcbp_rsp_item_type;

endpackage

// File: design/hcbp_ram.sv
// Single port-pair RAM: one write, one read, read data registered
module hcbp_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/huffman_code_bit_packer.sv
// Huffman bit packer: code table in RAM, bytes packed MSB first.
// Load writes a table entry. Encode reads the entry, left-aligns the code in the
// shifter, then one shifter step per cycle fills each output byte touched (1 to 5).
// Flush and shifter steps wait while a stalled result holds the output register.
// Synchronous reset clears the accumulator and handshake; table is not cleared.
module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hcbp_pkg::hcbp_req_item_type   req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hcbp_pkg::hcbp_rsp_item_type   rsp_data
);

   import hcbp_pkg::*;

`include "assert_macros.svh"

   // Stored length saturates to the smaller of the field limit and MAX_CODE_LEN
   localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int LEN_W   = $clog2(LEN_LIM + 1);
   localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
   localparam int ENTRY_W = CODE_W + LEN_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SHIFT,
      ST_FLUSH
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        accum_ff, accum_in;
   logic [2:0]        bitpos_ff, bitpos_in;
   logic              pending_ff, pending_in;
   logic [CODE_W-1:0] sh_ff, sh_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hcbp_rsp_item_type rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               in_range;
   logic               out_free;
   logic               flush_go;
   logic               wr_en, rd_en;
   logic [LEN_W-1:0]   sat_len;
   logic [ENTRY_W-1:0] rd_entry;
   logic [CODE_W-1:0]  rd_code;
   logic [LEN_W-1:0]   rd_len;
   logic [5:0]         align_sh;
   logic [3:0]         free_bits, take;
   logic [5:0]         rem_wide;
   logic [5:0]         rem_left;
   logic               full;
   logic [7:0]         ins_bits, merged;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign in_range  = (9'(req_data.symbol) < 9'(SYMBOL_COUNT));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign flush_go  = (state_ff == ST_FLUSH) && out_free;

   // Length saturation on load
   assign sat_len = (req_data.code_length > LEN_FIELD_W'(LEN_LIM)) ?
                    LEN_W'(LEN_LIM) : req_data.code_length[LEN_W-1:0];

   assign wr_en = req_xfer && (req_data.req_type == REQ_LOAD) && in_range;
   assign rd_en = req_xfer && (req_data.req_type == REQ_ENCODE) && in_range;

   hcbp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SYMBOL_COUNT)
   ) u_code_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_data.symbol[ADDR_W-1:0]),
      .wr_data({sat_len, req_data.code_bits}),
      .rd_en  (rd_en),
      .rd_addr(req_data.symbol[ADDR_W-1:0]),
      .rd_data(rd_entry)
   );

   assign rd_code  = rd_entry[CODE_W-1:0];
   assign rd_len   = rd_entry[ENTRY_W-1:CODE_W];
   // Left-align the code so its first bit sits at the top of the shifter
   assign align_sh = 6'(CODE_W) - 6'(rd_len);

   // One byte step: fill the free bits of the accumulator from the shifter top
   assign free_bits = 4'({1'b0, bitpos_ff}) + 4'd1;
   assign rem_wide  = 6'(rem_ff);
   assign take      = (rem_wide < 6'(free_bits)) ? rem_wide[3:0] : free_bits;
   assign rem_left  = rem_wide - 6'(take);
   assign full      = (take == free_bits);
   assign ins_bits  = sh_ff[CODE_W-1:CODE_W-8] >> (TOP_BIT - bitpos_ff);
   assign merged    = accum_ff | ins_bits;

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      accum_in     = accum_ff;
      bitpos_in    = bitpos_ff;
      pending_in   = pending_ff;
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_data.req_type)
                  REQ_ENCODE: if (in_range) state_in = ST_LOOKUP;
                  REQ_FLUSH:  state_in = ST_FLUSH;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: begin
            sh_in    = rd_code << align_sh;
            rem_in   = rd_len;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (rem_ff == '0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               sh_in  = sh_ff << take;
               rem_in = rem_ff - LEN_W'(take);
               if (full) begin
                  // last when the bits left cannot fill another byte
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.out_byte = merged;
                  rsp_data_in.last     = (rem_left < 6'd8);
                  rsp_data_in.padded   = 1'b0;
                  accum_in             = '0;
                  bitpos_in            = TOP_BIT;
                  pending_in           = 1'b0;
               end else begin
                  accum_in   = merged;
                  bitpos_in  = bitpos_ff - take[2:0];
                  pending_in = 1'b1;
               end
               if (rem_ff == LEN_W'(take)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (flush_go) begin
               if (pending_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.out_byte = accum_ff;
                  rsp_data_in.last     = 1'b1;
                  rsp_data_in.padded   = 1'b1;
               end
               accum_in   = '0;
               bitpos_in  = TOP_BIT;
               pending_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         accum_ff     <= '0;
         bitpos_ff    <= TOP_BIT;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         bitpos_ff    <= bitpos_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sh_ff       <= sh_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `ASSERT_NEVER(a_pending_matches_pos, clock, reset, pending_ff != (bitpos_ff != TOP_BIT))
   `ASSERT_PROP(a_padded_is_last, clock, reset, (rsp_valid && rsp_data.padded) |-> rsp_data.last)
   `ASSERT_PROP(a_flush_clears, clock, reset, flush_go |=> (!pending_ff && accum_ff == '0))

endmodule
